[hw/rtl/swmq_pkg.sv]
// Shared types and constants for the sliding-window mean queue.
`default_nettype none

package swmq_pkg;

   localparam int HEIGHT_W       = 12;
   localparam int RING_SLOTS_DEF = 8;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 24;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [HEIGHT_W-1:0] height;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV
   } back_state_type;

endpackage

`default_nettype wire

[hw/rtl/sliding_window_mean_queue.sv]
// Sliding-window mean queue: top level.
//
// A FIFO of up to RING_SLOTS-1 twelve-bit heights with a running sum and count.
// Request channel (req_*): one transfer per item; req_tuser is the op
// (0 insert req_tdata[11:0], 1 remove the oldest value).
// Response channel (rsp_*): one transfer per item, in order. rsp_tdata carries
// the removed value and the truncated mean of the contents after the item;
// rsp_tuser flags a remove from an empty queue (state is left untouched then).
// An insert into a full ring drops the oldest value first.
// A two-entry input queue decouples intake from execution. Each item
// passes through the back end's IDLE, EXEC and DIV states, one item at a time;
// in DIV it waits for the one-bit-per-cycle divider producing the mean and for
// the output register to be free.
// A stalled response is held in the output register while the next item is
// taken and executed; that item then waits for the register to free up.
// Reset (synchronous, active high) empties the queue and clears the sum;
// ring contents are not cleared and are only read after being written.
`default_nettype none

module sliding_window_mean_queue #(
   parameter int RING_SLOTS = swmq_pkg::RING_SLOTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [swmq_pkg::REQ_DATA_W-1:0] req_tdata,  // [11:0] height, [15:12] zero
   input  wire logic                            req_tuser,  // [0] op
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [swmq_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [11:0] removed_height, [23:12] mean_height
   output logic                                 rsp_tuser   // [0] empty_error
);
   import swmq_pkg::*;

   localparam int CNT_W = $clog2(RING_SLOTS);
   localparam int SUM_W = HEIGHT_W + CNT_W;

   item_type         item;
   logic             item_valid;
   logic             item_ready;
   logic             div_start;
   logic [SUM_W-1:0] div_dividend;
   logic [CNT_W-1:0] div_divisor;
   logic             div_done;
   logic [SUM_W-1:0] div_quotient;
   logic [CNT_W-1:0] held_count;

   swmq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item       (item),
      .item_valid (item_valid),
      .item_ready (item_ready)
   );

   swmq_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   swmq_back #(
      .RING_SLOTS (RING_SLOTS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .item_valid   (item_valid),
      .item_ready   (item_ready),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient),
      .held_count   (held_count),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

   // occupancy never exceeds one less than the slot count
   assert property (@(posedge clock) disable iff (reset)
      held_count <= CNT_W'(RING_SLOTS - 1))
      else $error("held count exceeds ring capacity");

   // an empty-queue error reports neither a removed value nor a mean
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("error response carries nonzero data");

   // the divider is only started when the previous result has been consumed; a start clears its done flag
   assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done)
      else $error("divider done flag not cleared on start");

endmodule

`default_nettype wire

[hw/rtl/swmq_front.sv]
// Front end: accepts request transfers, decodes the op and buffers items in a two-entry queue.
`default_nettype none

module swmq_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [swmq_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,
   output swmq_pkg::item_type                   item,
   output logic                                 item_valid,
   input  wire logic                            item_ready
);
   import swmq_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   logic       pop;
   item_type   new_item;

   // no transfer is taken while reset is held
   assign req_tready = !reset && (fill_ff != 2'd2);
   assign item_valid = (fill_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   assign push = req_tvalid && req_tready;
   assign pop  = item_valid && item_ready;

   always_comb begin
      new_item.op     = op_type'(req_tuser);
      new_item.height = req_tdata[HEIGHT_W-1:0];
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/swmq_div.sv]
// Restoring serial divider: one quotient bit per cycle.
`default_nettype none

module swmq_div #(
   parameter  int DIVIDEND_W = 15,
   parameter  int DIVISOR_W  = 3,
   localparam int CYC_W      = $clog2(DIVIDEND_W + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   logic                  busy_ff;
   logic                  busy_in;
   logic                  done_ff;
   logic                  done_in;
   logic [CYC_W-1:0]      cyc_ff;
   logic [CYC_W-1:0]      cyc_in;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVIDEND_W-1:0] quo_in;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVISOR_W-1:0]  dvs_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cyc_in  = cyc_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cyc_in  = CYC_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits of the difference suffice
         rem_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cyc_in = cyc_ff - 1'b1;
         if (cyc_ff == CYC_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cyc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cyc_ff  <= cyc_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

`default_nettype wire

[hw/rtl/swmq_back.sv]
// Back end: ring memory, running sum and count, divider sequencing and the response register.
`default_nettype none

module swmq_back #(
   parameter  int RING_SLOTS = swmq_pkg::RING_SLOTS_DEF,
   localparam int CNT_W      = $clog2(RING_SLOTS),
   localparam int SUM_W      = swmq_pkg::HEIGHT_W + CNT_W
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire swmq_pkg::item_type              item,
   input  wire logic                            item_valid,
   output logic                                 item_ready,
   output logic                                 div_start,
   output logic [SUM_W-1:0]                     div_dividend,
   output logic [CNT_W-1:0]                     div_divisor,
   input  wire logic                            div_done,
   input  wire logic [SUM_W-1:0]                div_quotient,
   output logic [CNT_W-1:0]                     held_count,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [swmq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tuser
);
   import swmq_pkg::*;

   localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(RING_SLOTS - 1);

   back_state_type      state_ff;
   back_state_type      state_in;

   logic [HEIGHT_W-1:0] ring_mem [RING_SLOTS];
   logic [HEIGHT_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]    head_ff;
   logic [CNT_W-1:0]    head_in;
   logic [CNT_W-1:0]    tail_ff;
   logic [CNT_W-1:0]    tail_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;

   item_type            item_ff;
   logic [HEIGHT_W-1:0] removed_ff;
   logic [HEIGHT_W-1:0] removed_in;
   logic                error_ff;
   logic                error_in;
   logic                wr_en;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [HEIGHT_W-1:0] rsp_removed_ff;
   logic [HEIGHT_W-1:0] rsp_mean_ff;
   logic [HEIGHT_W-1:0] mean;
   logic                rsp_error_ff;

   logic                take_item;
   logic                exec_en;
   logic                out_load;
   logic                full;
   logic                empty;

   function automatic logic [CNT_W-1:0] next_slot(input logic [CNT_W-1:0] slot);
      next_slot = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
   endfunction

   assign full  = (count_ff == LAST_SLOT);
   assign empty = (count_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done && (!rsp_valid_ff || rsp_tready)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      item_ready = 1'b0;
      exec_en    = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
         end
         ST_EXEC: begin
            exec_en = 1'b1;
         end
         ST_DIV: begin
            out_load = div_done && (!rsp_valid_ff || rsp_tready);
         end
         default: begin
            item_ready = 1'b0;
         end
      endcase
   end

   assign take_item    = item_ready && item_valid;
   assign div_start    = exec_en;
   assign div_dividend = sum_in;
   assign div_divisor  = count_in;
   assign held_count   = count_ff;

   // rd_data_ff holds the head entry; head is stable while idle, so it is current in EXEC
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      removed_in = '0;
      error_in   = 1'b0;
      wr_en      = 1'b0;
      unique case (item_ff.op)
         OP_INSERT: begin
            wr_en   = exec_en;
            tail_in = next_slot(tail_ff);
            if (full) begin
               // ring full: oldest value drops out silently
               head_in = next_slot(head_ff);
               sum_in  = sum_ff - SUM_W'(rd_data_ff) + SUM_W'(item_ff.height);
            end else begin
               count_in = count_ff + 1'b1;
               sum_in   = sum_ff + SUM_W'(item_ff.height);
            end
         end
         OP_REMOVE: begin
            if (empty) begin
               error_in = 1'b1;
            end else begin
               removed_in = rd_data_ff;
               head_in    = next_slot(head_ff);
               count_in   = count_ff - 1'b1;
               sum_in     = sum_ff - SUM_W'(rd_data_ff);
            end
         end
         default: begin
            error_in = 1'b0;
         end
      endcase
   end

   assign mean = (count_ff == '0) ? '0 : div_quotient[HEIGHT_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[tail_ff] <= item_ff.height;
      end
      rd_data_ff <= ring_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_en) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_item) begin
         item_ff <= item;
      end
      if (exec_en) begin
         removed_ff <= removed_in;
         error_ff   <= error_in;
      end
      if (out_load) begin
         rsp_removed_ff <= removed_ff;
         rsp_mean_ff    <= mean;
         rsp_error_ff   <= error_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_mean_ff, rsp_removed_ff};
   assign rsp_tuser  = rsp_error_ff;

endmodule

`default_nettype wire
